/* hdl/mtfr_pkg.sv */
// Shared types, constants and an arithmetic helper for the multitap feedback reverb.
`timescale 1ns / 1ps

package mtfr_pkg;

  localparam int DEF_DELAY_DEPTH = 2048;
  localparam int SAMPLE_W        = 24;
  localparam int GAIN_W          = 16;
  localparam int TAP_N           = 4;
  localparam int TSUM_W          = 41;   // exact tap sum, |T| < 2^40
  localparam int PROD_W          = 58;   // widest product and accumulation
  localparam int CFG_IDX_W       = 2;

  localparam logic [10:0] TAP_DIST [TAP_N] = '{11'd147, 11'd341, 11'd689, 11'd1123};
  localparam logic [15:0] TAP_WT   [TAP_N] = '{16'd39322, 16'd26214, 16'd19661, 16'd13107};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLE   = 2'd0,
    CFG_DRY_GAIN = 2'd1,
    CFG_WET_GAIN = 2'd2,
    CFG_FB_GAIN  = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    MUL_TAP   = 2'd0,
    MUL_X_DRY = 2'd1,
    MUL_T_FB  = 2'd2,
    MUL_T_WET = 2'd3
  } mul_sel_t;

  typedef struct packed {
    logic     load;
    logic     rd_en;
    logic     tap_vld;
    logic [1:0] k;
    mul_sel_t mul_sel;
    logic     acc_en;
    logic     acc_first;
    logic     sum_ld;
    logic     wr_en;
    logic     res_ld;
  } ctl_t;

  // Round half up at bit 32, then clamp to the 24-bit sample range.
  function automatic logic [SAMPLE_W-1:0] sat_round(input logic signed [PROD_W-1:0] v);
    logic signed [PROD_W-1:0] t;
    logic signed [PROD_W-33:0] q;
    t = v + 58'sd2147483648;
    q = t[PROD_W-1:32];
    if (q > 26'sd8388607) begin
      return 24'h7FFFFF;
    end else if (q < -26'sd8388608) begin
      return 24'h800000;
    end else begin
      return q[SAMPLE_W-1:0];
    end
  endfunction

endpackage

/* hdl/mtfr_ctrl.sv */
// Frame sequencer: step counter, shared write index, fill tracking and tap addressing.
`timescale 1ns / 1ps

module mtfr_ctrl #(
  parameter int DELAY_DEPTH = mtfr_pkg::DEF_DELAY_DEPTH,
  parameter int AW          = $clog2(DELAY_DEPTH)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_fire,
  input  logic          enable,
  input  logic          out_free,
  output logic          in_ready,
  output logic          out_load,
  output mtfr_pkg::ctl_t ctl,
  output logic [AW-1:0] rd_addr,
  output logic [AW-1:0] wr_addr
);
  import mtfr_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  localparam logic [3:0] STEP_ACC0 = 4'd2;
  localparam logic [3:0] STEP_XD   = 4'd5;
  localparam logic [3:0] STEP_FB   = 4'd6;
  localparam logic [3:0] STEP_WR   = 4'd7;
  localparam logic [3:0] STEP_LAST = 4'd8;
  localparam logic [AW-1:0] IDX_LAST = AW'(DELAY_DEPTH - 1);

  state_t        state_r, state_nxt;
  logic [3:0]    step_r, step_nxt;
  logic [AW-1:0] wr_idx_r, wr_idx_nxt;
  logic          wrap_r, wrap_nxt;
  logic [AW-1:0] tap_off;
  logic [1:0]    rk;

  assign in_ready = (state_r == ST_IDLE);
  assign out_load = (state_r == ST_DONE) && out_free;
  assign wr_addr  = wr_idx_r;

  assign rk      = step_r[1:0];
  assign tap_off = AW'(TAP_DIST[rk]);

  always_comb begin
    if (wr_idx_r >= tap_off) begin
      rd_addr = wr_idx_r - tap_off;
    end else begin
      rd_addr = AW'({1'b0, wr_idx_r} + (AW+1)'(DELAY_DEPTH) - {1'b0, tap_off});
    end
  end

  always_comb begin
    ctl         = '0;
    ctl.load    = in_fire;
    ctl.mul_sel = MUL_TAP;
    if (state_r == ST_RUN) begin
      ctl.rd_en     = (step_r < 4'd4);
      // entries not yet written since reset read as zero
      ctl.tap_vld   = wrap_r || (wr_idx_r >= tap_off);
      ctl.k         = 2'(step_r - 4'd1);
      ctl.acc_en    = (step_r >= STEP_ACC0) && (step_r <= STEP_XD);
      ctl.acc_first = (step_r == STEP_ACC0);
      ctl.sum_ld    = (step_r == STEP_FB);
      ctl.wr_en     = (step_r == STEP_WR);
      ctl.res_ld    = (step_r == STEP_LAST);
      if (step_r == STEP_XD) begin
        ctl.mul_sel = MUL_X_DRY;
      end else if (step_r == STEP_FB) begin
        ctl.mul_sel = MUL_T_FB;
      end else if (step_r == STEP_WR) begin
        ctl.mul_sel = MUL_T_WET;
      end
    end
  end

  always_comb begin
    state_nxt  = state_r;
    step_nxt   = step_r;
    wr_idx_nxt = wr_idx_r;
    wrap_nxt   = wrap_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          step_nxt  = '0;
          state_nxt = enable ? ST_RUN : ST_DONE;
        end
      end
      ST_RUN: begin
        step_nxt = step_r + 4'd1;
        if (step_r == STEP_WR) begin
          // advance once per frame, after both channels are written
          wr_idx_nxt = (wr_idx_r == IDX_LAST) ? '0 : wr_idx_r + AW'(1);
          wrap_nxt   = wrap_r || (wr_idx_r == IDX_LAST);
        end
        if (step_r == STEP_LAST) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      step_r   <= '0;
      wr_idx_r <= '0;
      wrap_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      step_r   <= step_nxt;
      wr_idx_r <= wr_idx_nxt;
      wrap_r   <= wrap_nxt;
    end
  end

endmodule

/* hdl/mtfr_lane.sv */
// One channel: delay line memory, shared multiplier, tap accumulator and saturation.
`timescale 1ns / 1ps

module mtfr_lane #(
  parameter int DELAY_DEPTH = mtfr_pkg::DEF_DELAY_DEPTH,
  parameter int AW          = $clog2(DELAY_DEPTH)
) (
  input  logic                          clk,
  input  mtfr_pkg::ctl_t                ctl,
  input  logic [AW-1:0]                 rd_addr,
  input  logic [AW-1:0]                 wr_addr,
  input  logic [mtfr_pkg::SAMPLE_W-1:0] din,
  input  logic [mtfr_pkg::GAIN_W-1:0]   dry_gain,
  input  logic [mtfr_pkg::GAIN_W-1:0]   wet_gain,
  input  logic [mtfr_pkg::GAIN_W-1:0]   fb_gain,
  output logic [mtfr_pkg::SAMPLE_W-1:0] dout
);
  import mtfr_pkg::*;

  logic [SAMPLE_W-1:0]        mem [DELAY_DEPTH];
  logic [SAMPLE_W-1:0]        q_r;
  logic                       vld_r;
  logic signed [SAMPLE_W-1:0] x_r;
  logic signed [SAMPLE_W-1:0] tap;
  logic signed [TSUM_W-1:0]   acc_r;
  logic signed [PROD_W-1:0]   prod_r;
  logic signed [PROD_W-1:0]   sum_r;
  logic [SAMPLE_W-1:0]        res_r;
  logic signed [TSUM_W-1:0]   mul_a;
  logic signed [GAIN_W:0]     mul_b;
  logic signed [PROD_W-1:0]   x_hi;

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      q_r   <= mem[rd_addr];
      vld_r <= ctl.tap_vld;
    end
    if (ctl.wr_en) begin
      mem[wr_addr] <= sat_round(prod_r + x_hi);
    end
  end

  assign tap  = vld_r ? $signed(q_r) : '0;
  assign x_hi = $signed({{2{x_r[SAMPLE_W-1]}}, x_r, 32'b0});

  always_comb begin
    case (ctl.mul_sel)
      MUL_TAP: begin
        mul_a = {{(TSUM_W-SAMPLE_W){tap[SAMPLE_W-1]}}, tap};
        mul_b = $signed({1'b0, TAP_WT[ctl.k]});
      end
      MUL_X_DRY: begin
        mul_a = {{(TSUM_W-SAMPLE_W){x_r[SAMPLE_W-1]}}, x_r};
        mul_b = $signed({1'b0, dry_gain});
      end
      MUL_T_FB: begin
        mul_a = acc_r;
        mul_b = $signed({1'b0, fb_gain});
      end
      default: begin
        mul_a = acc_r;
        mul_b = $signed({1'b0, wet_gain});
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    if (ctl.acc_en) begin
      acc_r <= ctl.acc_first ? prod_r[TSUM_W-1:0] : acc_r + prod_r[TSUM_W-1:0];
    end
    if (ctl.sum_ld) begin
      sum_r <= prod_r <<< 16;
    end
    // the input lands in the result as well, which is what bypass hands on
    if (ctl.load) begin
      x_r   <= din;
      res_r <= din;
    end else if (ctl.res_ld) begin
      res_r <= sat_round(sum_r + prod_r);
    end
  end

  assign dout = res_r;

endmodule

/* hdl/multitap_feedback_reverb_core.sv */
// Top level of the stereo multitap feedback reverb: registers, handshakes and two lanes.
`timescale 1ns / 1ps

//  channel | direction | tdata (low bit up)           | handshake
//  in_     | slave     | left_in[23:0], right_in      | in_tvalid / in_tready
//  out_    | master    | left_out[23:0], right_out    | out_tvalid / out_tready
//  cfg_    | write     | cfg_index selects, cfg_data  | cfg_we, no back-pressure
//
// An enabled frame runs four sequential tap reads from each channel's single-port
// delay memory, overlapped with seven passes through one multiplier per channel, a
// final round, then the output load; bypass goes straight to the output load.
// Reset is synchronous; the delay lines are not swept, unwritten entries read as
// zero via a wrap flag on the write index. A stalled output holds the block after
// the frame finishes; the memory write and index advance are already done.

module multitap_feedback_reverb_core #(
  parameter int DELAY_DEPTH = mtfr_pkg::DEF_DELAY_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [2*mtfr_pkg::SAMPLE_W-1:0] in_tdata,   // left_in, right_in
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [2*mtfr_pkg::SAMPLE_W-1:0] out_tdata,  // left_out, right_out
  input  logic                            cfg_we,
  input  logic [mtfr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mtfr_pkg::GAIN_W-1:0]     cfg_data
);
  import mtfr_pkg::*;

  localparam int AW = $clog2(DELAY_DEPTH);

  logic                  enable_r;
  logic [GAIN_W-1:0]     dry_r, wet_r, fb_r;
  logic                  out_valid_r;
  logic [2*SAMPLE_W-1:0] out_data_r;
  logic                  in_fire, out_free, out_load;
  ctl_t                  ctl;
  logic [AW-1:0]         rd_addr, wr_addr;
  logic [SAMPLE_W-1:0]   left_res, right_res;

  assign in_fire    = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b0;
      dry_r    <= 16'd45875;
      wet_r    <= 16'd19661;
      fb_r     <= 16'd55706;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ENABLE:   enable_r <= cfg_data[0];
        CFG_DRY_GAIN: dry_r    <= cfg_data;
        CFG_WET_GAIN: wet_r    <= cfg_data;
        CFG_FB_GAIN:  fb_r     <= cfg_data;
        default:      ;
      endcase
    end
  end

  mtfr_ctrl #(
    .DELAY_DEPTH(DELAY_DEPTH),
    .AW         (AW)
  ) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_fire),
    .enable  (enable_r),
    .out_free(out_free),
    .in_ready(in_tready),
    .out_load(out_load),
    .ctl     (ctl),
    .rd_addr (rd_addr),
    .wr_addr (wr_addr)
  );

  mtfr_lane #(
    .DELAY_DEPTH(DELAY_DEPTH),
    .AW         (AW)
  ) u_left (
    .clk     (clk),
    .ctl     (ctl),
    .rd_addr (rd_addr),
    .wr_addr (wr_addr),
    .din     (in_tdata[SAMPLE_W-1:0]),
    .dry_gain(dry_r),
    .wet_gain(wet_r),
    .fb_gain (fb_r),
    .dout    (left_res)
  );

  mtfr_lane #(
    .DELAY_DEPTH(DELAY_DEPTH),
    .AW         (AW)
  ) u_right (
    .clk     (clk),
    .ctl     (ctl),
    .rd_addr (rd_addr),
    .wr_addr (wr_addr),
    .din     (in_tdata[2*SAMPLE_W-1:SAMPLE_W]),
    .dry_gain(dry_r),
    .wet_gain(wet_r),
    .fb_gain (fb_r),
    .dout    (right_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= {right_res, left_res};
    end
  end

endmodule

/* hdl/mtfr_chk.sv */
// Port-level checks on the reverb core, bound to the top level.
`timescale 1ns / 1ps

module mtfr_chk (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [2*mtfr_pkg::SAMPLE_W-1:0] out_tdata
);

  // a result held back must not change
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("out transaction changed while stalled");

  // one frame in flight: no second transaction straight after one is taken
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("in transaction accepted while a frame is in flight");

  // a fresh result appears only as the sequencer returns to idle
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> in_tready)
    else $error("result issued while a frame is still in flight");

  // reset drops the output side
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("out_tvalid high after reset");

endmodule

bind multitap_feedback_reverb_core mtfr_chk u_mtfr_chk (.*);
